>>> rtl/core/itf_pkg.sv
// Shared types, codes and helpers for the integer-to-text formatter.
`default_nettype none
package itf_pkg;

    localparam int RADIX_W = 6;
    localparam int CNT_W   = 7;
    localparam int DIGIT_W = 6;
    localparam int FLAGS_W = 7;
    localparam int CHAR_W  = 8;

    localparam int FLAG_LEFT   = 0;
    localparam int FLAG_ZERO   = 1;
    localparam int FLAG_PLUS   = 2;
    localparam int FLAG_SPACE  = 3;
    localparam int FLAG_PREFIX = 4;
    localparam int FLAG_LOWER  = 5;
    localparam int FLAG_SIGNED = 6;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;

    localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_UP_X   = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_LOW_X  = 8'h78;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_START,
        S_WAIT,
        S_PLAN,
        S_PADL,
        S_SIGN,
        S_PFX0,
        S_PFX1,
        S_ZPAD,
        S_PREC,
        S_DRD,
        S_DOUT,
        S_PADR
    } t_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic lower);
        logic [CHAR_W-1:0] base;
        base = lower ? CHAR_LOW_A : CHAR_UP_A;
        if (d < DEC_DIGITS) begin
            return CHAR_ZERO + {2'b00, d};
        end
        return base + {2'b00, d - DEC_DIGITS};
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/itf_if.sv
// Request and result channel interfaces of the formatter.
`default_nettype none
interface itf_req_if #(
    parameter int VALUE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic [VALUE_BITS-1:0]         value;
    logic [itf_pkg::RADIX_W-1:0]   radix;
    logic [itf_pkg::CNT_W-1:0]     fld_width;
    logic [itf_pkg::DIGIT_W-1:0]   min_digits;
    logic [itf_pkg::FLAGS_W-1:0]   format_flags;

    modport source (output valid, value, radix, fld_width, min_digits, format_flags,
                    input ready);
    modport sink (input valid, value, radix, fld_width, min_digits, format_flags,
                  output ready);
endinterface

interface itf_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [itf_pkg::CHAR_W-1:0]   out_char;
    logic                         last_char;
    logic                         bad_radix;

    modport source (output valid, out_char, last_char, bad_radix, input ready);
    modport sink (input valid, out_char, last_char, bad_radix, output ready);
endinterface
`default_nettype wire

>>> rtl/core/integer_to_text_formatter.sv
// Top level: printf-style integer to text conversion, radix 2 to 36.
// Each request carries a value, a radix, a field width, a minimum digit count and format
// flags; the block answers with the formatted text, one character per result, with
// last_char on the final one. A radix outside 2..36 gives a single result with a NUL
// character and bad_radix set. Field width saturates at MAX_FIELD and the digit count at
// MAX_DIGITS. Conversion runs on one restoring divider that produces one quotient bit a
// cycle, one division per digit. Digits go to a digit RAM and are read back one at a
// time, a read state then an output state for each; every padding or leading-zero
// character is emitted on its own, sign and prefix have their own states, and the start,
// wait and plan states sequence the conversion. No new request is taken until the last
// character has been loaded into the output register.
`default_nettype none
module integer_to_text_formatter #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 32,
    parameter int MAX_FIELD  = 64
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    itf_req_if.sink  i_req,
    itf_rsp_if.source o_rsp
);

    localparam int NW = $clog2(VALUE_BITS + 1);
    localparam int AW = $clog2(VALUE_BITS);
    localparam int CW = itf_pkg::CNT_W;

    itf_pkg::t_state r_state, n_state;

    logic [itf_pkg::RADIX_W-1:0] r_radix, n_radix;
    logic [CW-1:0]               r_width, n_width;
    logic [CW-1:0]               r_prec, n_prec;
    logic [itf_pkg::FLAGS_W-1:0] r_flags, n_flags;
    logic [itf_pkg::CHAR_W-1:0]  r_sign, n_sign;
    logic [VALUE_BITS-1:0]       r_work, n_work;
    logic [NW-1:0]               r_n, n_n;
    logic [NW-1:0]               r_k, n_k;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [CW-1:0]               r_pad, n_pad;
    logic [CW-1:0]               r_left, n_left;
    logic                        r_out_valid, n_out_valid;
    logic [itf_pkg::CHAR_W-1:0]  r_out_char, n_out_char;
    logic                        r_out_last, n_out_last;
    logic                        r_out_bad, n_out_bad;

    logic                        can_emit, emit, e_bad;
    logic [itf_pkg::CHAR_W-1:0]  e_char;
    logic                        div_start, div_done;
    logic [VALUE_BITS-1:0]       div_quot;
    logic [itf_pkg::RADIX_W-1:0] div_rem;
    logic                        ram_we, ram_re;
    logic [itf_pkg::DIGIT_W-1:0] ram_rdata;
    logic [1:0]                  pfx_len;
    logic [1:0]                  sign_len;
    logic [CW:0]                 fixed_len;
    logic [CW-1:0]               n_ext, prec_eff, pad_calc;
    logic [CW-1:0]               in_width, in_prec;
    logic [itf_pkg::FLAGS_W-1:0] in_flags;
    logic                        in_neg;
    logic                        in_bad;

    itf_div #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_work),
        .i_divisor  (r_radix),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    itf_ram #(
        .WIDTH(itf_pkg::DIGIT_W),
        .DEPTH(VALUE_BITS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_n[AW-1:0]),
        .i_wdata (div_rem),
        .i_re    (ram_re),
        .i_raddr (AW'(r_k - 1'b1)),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        in_bad   = (i_req.radix < itf_pkg::RADIX_MIN) || (i_req.radix > itf_pkg::RADIX_MAX);
        in_width = (i_req.fld_width > CW'(MAX_FIELD)) ? CW'(MAX_FIELD) : i_req.fld_width;
        in_prec  = ({1'b0, i_req.min_digits} > CW'(MAX_DIGITS)) ? CW'(MAX_DIGITS)
                                                                : {1'b0, i_req.min_digits};
        in_flags = i_req.format_flags;
        if (in_flags[itf_pkg::FLAG_LEFT]) begin
            in_flags[itf_pkg::FLAG_ZERO] = 1'b0;
        end
        in_neg = in_flags[itf_pkg::FLAG_SIGNED] && i_req.value[VALUE_BITS-1];

        pfx_len = 2'd0;
        if (r_flags[itf_pkg::FLAG_PREFIX]) begin
            if (r_radix == itf_pkg::RADIX_HEX) begin
                pfx_len = 2'd2;
            end else if (r_radix == itf_pkg::RADIX_OCT) begin
                pfx_len = 2'd1;
            end
        end
        sign_len  = (r_sign != itf_pkg::CHAR_NUL) ? 2'd1 : 2'd0;
        n_ext     = CW'(r_n);
        prec_eff  = (n_ext > r_prec) ? n_ext : r_prec;
        fixed_len = {1'b0, prec_eff} + (CW + 1)'(sign_len) + (CW + 1)'(pfx_len);
        pad_calc  = ({1'b0, r_width} > fixed_len) ? CW'({1'b0, r_width} - fixed_len) : '0;
    end

    always_comb begin
        can_emit    = !r_out_valid || o_rsp.ready;
        emit        = 1'b0;
        e_bad       = 1'b0;
        e_char      = itf_pkg::CHAR_NUL;
        div_start   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        i_req.ready = 1'b0;
        n_state     = r_state;
        n_radix     = r_radix;
        n_width     = r_width;
        n_prec      = r_prec;
        n_flags     = r_flags;
        n_sign      = r_sign;
        n_work      = r_work;
        n_n         = r_n;
        n_k         = r_k;
        n_cnt       = r_cnt;
        n_pad       = r_pad;
        n_left      = r_left;

        case (r_state)
            itf_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    if (in_bad) begin
                        n_state = itf_pkg::S_ERR;
                    end else begin
                        n_radix = i_req.radix;
                        n_width = in_width;
                        n_prec  = in_prec;
                        n_flags = in_flags;
                        if (in_neg) begin
                            n_sign = itf_pkg::CHAR_MINUS;
                        end else if (in_flags[itf_pkg::FLAG_PLUS]) begin
                            n_sign = itf_pkg::CHAR_PLUS;
                        end else if (in_flags[itf_pkg::FLAG_SPACE]) begin
                            n_sign = itf_pkg::CHAR_SPACE;
                        end else begin
                            n_sign = itf_pkg::CHAR_NUL;
                        end
                        n_work  = in_neg ? (VALUE_BITS'(0) - i_req.value) : i_req.value;
                        n_n     = '0;
                        n_state = itf_pkg::S_START;
                    end
                end
            end
            itf_pkg::S_ERR: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    e_bad   = 1'b1;
                    n_state = itf_pkg::S_IDLE;
                end
            end
            itf_pkg::S_START: begin
                div_start = 1'b1;
                n_state   = itf_pkg::S_WAIT;
            end
            itf_pkg::S_WAIT: begin
                if (div_done) begin
                    ram_we = 1'b1;
                    n_n    = r_n + 1'b1;
                    n_work = div_quot;
                    if ((div_quot != '0) && ((r_n + 1'b1) < NW'(VALUE_BITS))) begin
                        n_state = itf_pkg::S_START;
                    end else begin
                        n_state = itf_pkg::S_PLAN;
                    end
                end
            end
            itf_pkg::S_PLAN: begin
                n_prec  = prec_eff;
                n_pad   = pad_calc;
                n_left  = CW'(fixed_len) + pad_calc;
                n_cnt   = (r_flags[itf_pkg::FLAG_LEFT] || r_flags[itf_pkg::FLAG_ZERO])
                          ? '0 : pad_calc;
                n_state = itf_pkg::S_PADL;
            end
            itf_pkg::S_PADL: begin
                if (r_cnt == '0) begin
                    n_state = itf_pkg::S_SIGN;
                end else if (can_emit) begin
                    emit   = 1'b1;
                    e_char = itf_pkg::CHAR_SPACE;
                    n_cnt  = r_cnt - 1'b1;
                end
            end
            itf_pkg::S_SIGN: begin
                if (sign_len == 2'd0) begin
                    n_state = itf_pkg::S_PFX0;
                end else if (can_emit) begin
                    emit    = 1'b1;
                    e_char  = r_sign;
                    n_state = itf_pkg::S_PFX0;
                end
            end
            itf_pkg::S_PFX0: begin
                if (pfx_len == 2'd0) begin
                    n_state = itf_pkg::S_PFX1;
                end else if (can_emit) begin
                    emit    = 1'b1;
                    e_char  = itf_pkg::CHAR_ZERO;
                    n_state = itf_pkg::S_PFX1;
                end
            end
            itf_pkg::S_PFX1: begin
                if (pfx_len != 2'd2 || can_emit) begin
                    if (pfx_len == 2'd2) begin
                        emit   = 1'b1;
                        e_char = r_flags[itf_pkg::FLAG_LOWER] ? itf_pkg::CHAR_LOW_X
                                                               : itf_pkg::CHAR_UP_X;
                    end
                    n_cnt   = r_flags[itf_pkg::FLAG_ZERO] ? r_pad : '0;
                    n_state = itf_pkg::S_ZPAD;
                end
            end
            itf_pkg::S_ZPAD: begin
                if (r_cnt == '0) begin
                    n_cnt   = r_prec - n_ext;
                    n_state = itf_pkg::S_PREC;
                end else if (can_emit) begin
                    emit   = 1'b1;
                    e_char = itf_pkg::CHAR_ZERO;
                    n_cnt  = r_cnt - 1'b1;
                end
            end
            itf_pkg::S_PREC: begin
                if (r_cnt == '0) begin
                    n_k     = r_n;
                    n_state = itf_pkg::S_DRD;
                end else if (can_emit) begin
                    emit   = 1'b1;
                    e_char = itf_pkg::CHAR_ZERO;
                    n_cnt  = r_cnt - 1'b1;
                end
            end
            itf_pkg::S_DRD: begin
                if (r_k == '0) begin
                    n_cnt   = r_flags[itf_pkg::FLAG_LEFT] ? r_pad : '0;
                    n_state = itf_pkg::S_PADR;
                end else begin
                    ram_re  = 1'b1;
                    n_state = itf_pkg::S_DOUT;
                end
            end
            itf_pkg::S_DOUT: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    e_char  = itf_pkg::digit_char(ram_rdata, r_flags[itf_pkg::FLAG_LOWER]);
                    n_k     = r_k - 1'b1;
                    n_state = itf_pkg::S_DRD;
                end
            end
            itf_pkg::S_PADR: begin
                if (r_cnt == '0) begin
                    n_state = itf_pkg::S_IDLE;
                end else if (can_emit) begin
                    emit   = 1'b1;
                    e_char = itf_pkg::CHAR_SPACE;
                    n_cnt  = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = itf_pkg::S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_bad   = r_out_bad;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_char  = e_char;
            n_out_bad   = e_bad;
            n_out_last  = e_bad || (r_left == CW'(1));
            if (!e_bad) begin
                n_left = r_left - 1'b1;
            end
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_work      <= '0;
            r_n         <= '0;
            r_k         <= '0;
            r_cnt       <= '0;
            r_pad       <= '0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_work      <= n_work;
            r_n         <= n_n;
            r_k         <= n_k;
            r_cnt       <= n_cnt;
            r_pad       <= n_pad;
            r_left      <= n_left;
        end
        r_radix    <= n_radix;
        r_width    <= n_width;
        r_prec     <= n_prec;
        r_flags    <= n_flags;
        r_sign     <= n_sign;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_bad  <= n_out_bad;
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.out_char  = r_out_char;
    assign o_rsp.last_char = r_out_last;
    assign o_rsp.bad_radix = r_out_bad;

    a_char_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !e_bad) |-> (r_left != '0))
        else $error("character emitted beyond planned length");

    a_all_chars_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == itf_pkg::S_PADR && r_cnt == '0) |-> (r_left == '0))
        else $error("request finished with characters unsent");

    a_digit_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_n < NW'(VALUE_BITS)))
        else $error("digit written past store");

    a_no_emit_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !emit)
        else $error("output overwritten while stalled");

endmodule
`default_nettype wire

>>> rtl/core/itf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module itf_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/itf_div.sv
// Restoring divider by a small radix, one quotient bit per cycle.
`default_nettype none
module itf_div #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [VALUE_BITS-1:0]         i_dividend,
    input  wire logic [itf_pkg::RADIX_W-1:0]   i_divisor,
    output logic                               o_done,
    output logic [VALUE_BITS-1:0]              o_quot,
    output logic [itf_pkg::RADIX_W-1:0]        o_rem
);

    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0]       r_quot, n_quot;
    logic [itf_pkg::RADIX_W-1:0] r_rem, n_rem;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic                        r_done, n_done;
    logic [itf_pkg::RADIX_W:0]   rem_sh;
    logic                        ge;

    always_comb begin
        rem_sh = {r_rem, r_quot[VALUE_BITS-1]};
        ge     = rem_sh >= {1'b0, i_divisor};
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_cnt  = CW'(VALUE_BITS);
        end else if (r_cnt != '0) begin
            n_quot = {r_quot[VALUE_BITS-2:0], ge};
            n_rem  = ge ? itf_pkg::RADIX_W'(rem_sh - {1'b0, i_divisor})
                        : itf_pkg::RADIX_W'(rem_sh);
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rem < i_divisor))
        else $error("remainder not below divisor");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_cnt == '0))
        else $error("divider restarted while busy");

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_cnt == '0))
        else $error("done while steps remain");

endmodule
`default_nettype wire

>>> dv/integer_to_text_formatter_tb.sv
// Self-checking testbench for integer_to_text_formatter: directed and random formatting requests.
module integer_to_text_formatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itf_pkg::*;

    localparam int VBITS          = 32;
    localparam int DIGIT_CAP      = 32;
    localparam int FIELD_CAP      = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 64;

    localparam logic [FLAGS_W-1:0] F_LEFT   = FLAGS_W'(1 << FLAG_LEFT);
    localparam logic [FLAGS_W-1:0] F_ZERO   = FLAGS_W'(1 << FLAG_ZERO);
    localparam logic [FLAGS_W-1:0] F_PLUS   = FLAGS_W'(1 << FLAG_PLUS);
    localparam logic [FLAGS_W-1:0] F_SPACE  = FLAGS_W'(1 << FLAG_SPACE);
    localparam logic [FLAGS_W-1:0] F_PREFIX = FLAGS_W'(1 << FLAG_PREFIX);
    localparam logic [FLAGS_W-1:0] F_LOWER  = FLAGS_W'(1 << FLAG_LOWER);
    localparam logic [FLAGS_W-1:0] F_SIGNED = FLAGS_W'(1 << FLAG_SIGNED);

    localparam logic [8*36-1:0] UPPER_GLYPHS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam logic [8*36-1:0] LOWER_GLYPHS = "0123456789abcdefghijklmnopqrstuvwxyz";
    localparam int              X_GLYPH      = 33;

    typedef struct {
        logic [VBITS-1:0]   value;
        logic [RADIX_W-1:0] radix;
        logic [CNT_W-1:0]   fld_width;
        logic [DIGIT_W-1:0] min_digits;
        logic [FLAGS_W-1:0] format_flags;
    } fmt_request_t;

    typedef struct {
        logic [CHAR_W-1:0] out_char;
        logic              last_char;
        logic              bad_radix;
    } fmt_char_t;

    logic clk = 1'b0;
    logic rst_n;

    itf_req_if #(.VALUE_BITS(VBITS)) req_if ();
    itf_rsp_if rsp_if ();

    integer_to_text_formatter #(
        .VALUE_BITS(VBITS),
        .MAX_DIGITS(DIGIT_CAP),
        .MAX_FIELD (FIELD_CAP)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    fmt_char_t          expected_chars[$];
    logic [DIGIT_W-1:0] digit_model[DIGIT_CAP];

    int send_idle_pct      = 0;
    int recv_stall_pct     = 0;
    int requests_sent      = 0;
    int bad_radix_sent     = 0;
    int chars_checked      = 0;
    int error_count        = 0;
    int quiet_cycles       = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Expected text for one request, pushed character by character.
    function automatic void predict_text(input fmt_request_t r);
        logic [FLAGS_W-1:0] flags;
        logic [VBITS-1:0]   mag;
        logic [VBITS-1:0]   rem_val;
        logic [CHAR_W-1:0]  sign_ch;
        logic [CHAR_W-1:0]  fill;
        logic [8*36-1:0]    glyphs;
        logic [CHAR_W-1:0]  text[$];
        int pad;
        int prec;
        int ndig;
        int k;
        if (r.radix < RADIX_MIN || r.radix > RADIX_MAX) begin
            expected_chars.push_back('{CHAR_NUL, 1'b1, 1'b1});
            return;
        end
        flags = r.format_flags;
        if (flags[FLAG_LEFT]) flags[FLAG_ZERO] = 1'b0;
        glyphs = flags[FLAG_LOWER] ? LOWER_GLYPHS : UPPER_GLYPHS;
        fill   = flags[FLAG_ZERO] ? CHAR_ZERO : CHAR_SPACE;
        pad    = (r.fld_width > FIELD_CAP) ? FIELD_CAP : int'(r.fld_width);
        prec   = (r.min_digits > DIGIT_CAP) ? DIGIT_CAP : int'(r.min_digits);

        mag     = r.value;
        sign_ch = CHAR_NUL;
        if (flags[FLAG_SIGNED] && mag[VBITS-1]) begin
            sign_ch = CHAR_MINUS;
            mag     = -mag;
        end else if (flags[FLAG_PLUS]) begin
            sign_ch = CHAR_PLUS;
        end else if (flags[FLAG_SPACE]) begin
            sign_ch = CHAR_SPACE;
        end
        if (sign_ch != CHAR_NUL) pad--;
        if (flags[FLAG_PREFIX]) begin
            if (r.radix == RADIX_HEX) pad -= 2;
            else if (r.radix == RADIX_OCT) pad--;
        end

        rem_val = mag;
        ndig    = 0;
        do begin
            digit_model[ndig] = DIGIT_W'(rem_val % r.radix);
            rem_val           = rem_val / r.radix;
            ndig++;
        end while (rem_val != 0 && ndig < VBITS);
        if (ndig > prec) prec = ndig;
        pad -= prec;

        if (!flags[FLAG_ZERO] && !flags[FLAG_LEFT]) begin
            for (k = 0; k < pad; k++) text.push_back(CHAR_SPACE);
            pad = 0;
        end
        if (sign_ch != CHAR_NUL) text.push_back(sign_ch);
        if (flags[FLAG_PREFIX]) begin
            if (r.radix == RADIX_OCT) begin
                text.push_back(CHAR_ZERO);
            end else if (r.radix == RADIX_HEX) begin
                text.push_back(CHAR_ZERO);
                text.push_back(glyphs[8*(35-X_GLYPH) +: 8]);
            end
        end
        if (!flags[FLAG_LEFT]) begin
            for (k = 0; k < pad; k++) text.push_back(fill);
            pad = 0;
        end
        for (k = ndig; k < prec; k++) text.push_back(CHAR_ZERO);
        for (k = ndig - 1; k >= 0; k--) text.push_back(glyphs[8*(35-int'(digit_model[k])) +: 8]);
        for (k = 0; k < pad; k++) text.push_back(CHAR_SPACE);

        foreach (text[i])
            expected_chars.push_back('{text[i], (i == text.size() - 1), 1'b0});
    endfunction

    function automatic fmt_request_t make_request(input logic [VBITS-1:0] v, input int radix,
                                                  input int width, input int digits,
                                                  input logic [FLAGS_W-1:0] flags);
        fmt_request_t r;
        r.value        = v;
        r.radix        = RADIX_W'(radix);
        r.fld_width    = CNT_W'(width);
        r.min_digits   = DIGIT_W'(digits);
        r.format_flags = flags;
        return r;
    endfunction

    // Called just after the clock rises; returns just after the request is accepted.
    task automatic send_request(input fmt_request_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.value        <= r.value;
        req_if.radix        <= r.radix;
        req_if.fld_width    <= r.fld_width;
        req_if.min_digits   <= r.min_digits;
        req_if.format_flags <= r.format_flags;
        do @(posedge clk); while (!(req_if.valid && req_if.ready));
        predict_text(r);
        requests_sent++;
        if (r.radix < RADIX_MIN || r.radix > RADIX_MAX) bad_radix_sent++;
    endtask

    task automatic run_random_requests(input int count);
        fmt_request_t r;
        int small_val;
        repeat (count) begin
            small_val = $urandom_range(40);
            case ($urandom_range(7))
                0:       r.value = VBITS'(small_val);
                1:       r.value = 32'hFFFF_FFFF - VBITS'(small_val);
                2:       r.value = 32'h8000_0000 + VBITS'(small_val);
                3:       r.value = 32'h7FFF_FFFF - VBITS'(small_val);
                default: r.value = $urandom;
            endcase
            case ($urandom_range(9))
                0:       r.radix = ($urandom_range(1) != 0) ? RADIX_W'($urandom_range(1))
                                                            : RADIX_W'($urandom_range(37, 63));
                1:       r.radix = RADIX_HEX;
                2:       r.radix = RADIX_OCT;
                3:       r.radix = 6'd10;
                default: r.radix = RADIX_W'($urandom_range(2, 36));
            endcase
            r.fld_width    = ($urandom_range(9) == 0) ? CNT_W'($urandom_range(65, 127))
                                                      : CNT_W'($urandom_range(40));
            r.min_digits   = ($urandom_range(9) == 0) ? DIGIT_W'($urandom_range(33, 63))
                                                      : DIGIT_W'($urandom_range(16));
            r.format_flags = FLAGS_W'($urandom_range(127));
            send_request(r);
        end
    endtask

    task automatic test_directed_cases();
        send_idle_pct  = 11;
        recv_stall_pct = 88;
        send_request(make_request(32'd0, 10, 0, 0, '0));
        send_request(make_request(32'd0, RADIX_HEX, 0, 0, F_PREFIX));
        send_request(make_request(32'd0, RADIX_OCT, 0, 0, F_PREFIX));
        send_request(make_request(32'hFFFF_FFFF, 2, 0, 0, '0));
        send_request(make_request(32'hFFFF_FFFF, 36, 0, 0, F_LOWER));
        send_request(make_request(32'hDEAD_BEEF, RADIX_HEX, 12, 0, F_PREFIX | F_ZERO));
        send_request(make_request(32'hDEAD_BEEF, RADIX_HEX, 14, 0, F_PREFIX | F_LOWER | F_LEFT));
        send_request(make_request(32'h8000_0000, 10, 0, 0, F_SIGNED));
        send_request(make_request(32'hFFFF_FFFF, 10, 8, 0, F_SIGNED | F_ZERO));
        send_request(make_request(32'h7FFF_FFFF, 10, 15, 0, F_SIGNED | F_PLUS));
        send_request(make_request(32'd42, 10, 6, 0, F_PLUS | F_SPACE));
        send_request(make_request(32'd42, 10, 6, 0, F_SPACE));
        send_request(make_request(32'd42, 10, 10, 0, F_LEFT | F_ZERO));
        send_request(make_request(32'd123, 10, 10, 6, F_ZERO));
        send_request(make_request(32'd7, RADIX_OCT, 127, 0, F_PREFIX));
        send_request(make_request(32'd7, 10, 0, 63, '0));
        send_request(make_request(32'd5, 2, 64, 32, F_LEFT));
        send_request(make_request(32'h1234_5678, 3, 0, 0, F_PREFIX));
        send_request(make_request(32'd0, 2, 5, 0, F_SIGNED | F_PLUS));
        send_request(make_request(32'hFFFF_FFFF, 36, 20, 5, '1));
        send_request(make_request(32'd99, 0, 10, 3, F_ZERO));
        send_request(make_request(32'd99, 1, 0, 0, '0));
        send_request(make_request(32'd99, 37, 0, 0, F_PREFIX));
        send_request(make_request(32'hFFFF_FFFF, 63, 127, 63, '1));
    endtask

    task automatic test_slow_receiver();
        send_idle_pct  = 11;
        recv_stall_pct = 88;
        run_random_requests(32);
    endtask

    task automatic test_slow_sender();
        send_idle_pct  = 88;
        recv_stall_pct = 11;
        run_random_requests(32);
    endtask

    task automatic test_full_rate();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_requests(32);
    endtask

    always @(posedge clk) rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk) begin : check_results
        fmt_char_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                error_count++;
                $error("unexpected result: out_char %h last_char %b bad_radix %b",
                       rsp_if.out_char, rsp_if.last_char, rsp_if.bad_radix);
            end else begin
                want = expected_chars.pop_front();
                if (rsp_if.out_char !== want.out_char) begin
                    error_count++;
                    $error("out_char: expected %h, got %h", want.out_char, rsp_if.out_char);
                end
                if (rsp_if.last_char !== want.last_char) begin
                    error_count++;
                    $error("last_char: expected %b, got %b", want.last_char, rsp_if.last_char);
                end
                if (rsp_if.bad_radix !== want.bad_radix) begin
                    error_count++;
                    $error("bad_radix: expected %b, got %b", want.bad_radix, rsp_if.bad_radix);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        rst_n               <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.value        <= '0;
        req_if.radix        <= '0;
        req_if.fld_width    <= '0;
        req_if.min_digits   <= '0;
        req_if.format_flags <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_slow_receiver();
        test_slow_sender();
        test_full_rate();
        req_if.valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Formatted %0d requests (%0d with an out-of-range radix), %0d characters checked,",
                 requests_sent, bad_radix_sent, chars_checked);
        $display("under slow-receiver, slow-sender and full-rate handshake pacing.");
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/itf_pkg.sv
rtl/core/itf_if.sv
rtl/core/itf_ram.sv
rtl/core/itf_div.sv
rtl/core/integer_to_text_formatter.sv
dv/integer_to_text_formatter_tb.sv
